// ----- rtl/rfm_pkg.sv -----
// Shared types and constants of the reciprocal frequency meter.
// Used by rfm_divider, rfm_poll, the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package rfm_pkg;

  localparam int DATA_W    = 32;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ_NUMERATOR     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US         = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL_US = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_SPACING_US  = 8'd3;

  localparam logic [DATA_W-1:0] FREQ_NUMERATOR_RST     = 32'd100000000;
  localparam logic [TIME_W-1:0] TIMEOUT_US_RST         = 32'd2000000;
  localparam logic [TIME_W-1:0] REPORT_INTERVAL_US_RST = 32'd1000000;
  localparam logic [TIME_W-1:0] CHANGE_SPACING_US_RST  = 32'd200000;
  localparam logic [DATA_W-1:0] LAST_REPORTED_RST      = 32'hFFFF_FFFF;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } rfm_state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic              lost;
    logic              report;
    logic [DATA_W-1:0] freq;
  } poll_rsp_t;

endpackage

// ----- rtl/rfm_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle for a DATA_W-bit quotient.
// Depends on rfm_pkg.
`timescale 1ns / 1ps

module rfm_divider (
  input  logic             clk,
  input  logic             rst,
  input  rfm_pkg::div_req_t req,
  output rfm_pkg::div_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [rfm_pkg::CNT_W-1:0]    cnt;
  logic [rfm_pkg::DATA_W-1:0]   rem;
  logic [rfm_pkg::DATA_W-1:0]   quot;
  logic [rfm_pkg::DATA_W-1:0]   den;
  logic [rfm_pkg::DATA_W:0]     shifted;
  logic [rfm_pkg::DATA_W+1:0]   diff;
  logic                         fits;

  // The numerator is shifted out at the top of quot while quotient bits enter at the bottom.
  assign shifted = {rem, quot[rfm_pkg::DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign fits    = ~diff[rfm_pkg::DATA_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == rfm_pkg::CNT_W'(rfm_pkg::DATA_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt  <= '0;
      rem  <= '0;
      quot <= req.num;
      den  <= req.den;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      rem  <= fits ? diff[rfm_pkg::DATA_W-1:0] : shifted[rfm_pkg::DATA_W-1:0];
      quot <= {quot[rfm_pkg::DATA_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ----- rtl/rfm_poll.sv -----
// Poll decision: signal-loss timeout and report throttling for one service poll.
// Depends on rfm_pkg.
`timescale 1ns / 1ps

module rfm_poll (
  input  logic [rfm_pkg::TIME_W-1:0] now,
  input  logic [rfm_pkg::TIME_W-1:0] last_edge_time,
  input  logic                       edge_seen,
  input  logic [rfm_pkg::DATA_W-1:0] frequency,
  input  logic [rfm_pkg::TIME_W-1:0] last_report_time,
  input  logic [rfm_pkg::DATA_W-1:0] last_reported_value,
  input  logic [rfm_pkg::TIME_W-1:0] timeout_us,
  input  logic [rfm_pkg::TIME_W-1:0] report_interval_us,
  input  logic [rfm_pkg::TIME_W-1:0] change_spacing_us,
  output rfm_pkg::poll_rsp_t         rsp
);

  logic [rfm_pkg::TIME_W-1:0] since_edge;
  logic [rfm_pkg::TIME_W-1:0] since_report;
  logic [rfm_pkg::DATA_W-1:0] freq_new;
  logic                       lost;

  // Differences wrap modulo the timestamp width.
  assign since_edge   = now - last_edge_time;
  assign since_report = now - last_report_time;
  assign lost         = edge_seen && (since_edge > timeout_us);
  assign freq_new     = lost ? '0 : frequency;

  assign rsp.lost   = lost;
  assign rsp.freq   = freq_new;
  assign rsp.report = (since_report >= report_interval_us) ||
                      ((freq_new != last_reported_value) &&
                       (since_report >= change_spacing_us));

endmodule

// ----- rtl/reciprocal_frequency_meter_unit.sv -----
// Top level of the reciprocal frequency meter: handshakes, configuration, state and sequencing.
// Depends on rfm_pkg, rfm_divider and rfm_poll.
`timescale 1ns / 1ps

// The input stream carries one request per edge or poll: s_tdata is the microsecond
// timestamp and s_tuser is the kind (0 = captured rising edge, 1 = service poll).
// Every request yields exactly one result on the output stream: m_tdata is the
// frequency in hundredths of a hertz held after the request, m_tuser[0] marks a
// poll that issues a report and m_tuser[1] a poll that cleared the frequency
// because no edge came within the timeout.
// An edge that follows an earlier edge with a nonzero period runs the bit-serial
// divider, which produces one quotient bit per cycle; such a request shows its
// result in the same cycle that the input is ready again, and no request is taken
// while the divider's 32 iterations run. All other requests pass through the push
// state into the output register; the next request waits until that result is pushed.
// The result sits in an output register, so a new request is taken while the
// receiver stalls; a second finished result waits until that register drains.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready and writes one register per request; unknown indexes are ignored. Writes are
// expected only while the block is idle.
// A synchronous reset restores the register defaults, forgets the previous edge,
// clears the frequency and the output register, and sets the last reported value
// to all ones.

module reciprocal_frequency_meter_unit (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [31:0] time_us
  input  logic                          s_tuser,   // [0] op
  // Output stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // [31:0] freq_x100
  output logic [1:0]                    m_tuser,   // [0] report_valid, [1] signal_lost
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  rfm_pkg::rfm_state_t state;
  rfm_pkg::rfm_state_t state_next;

  // Configuration registers.
  logic [rfm_pkg::DATA_W-1:0] freq_numerator;
  logic [rfm_pkg::TIME_W-1:0] timeout_us;
  logic [rfm_pkg::TIME_W-1:0] report_interval_us;
  logic [rfm_pkg::TIME_W-1:0] change_spacing_us;

  // Measurement state.
  logic [rfm_pkg::TIME_W-1:0] last_edge_time;
  logic                       edge_seen;
  logic [rfm_pkg::DATA_W-1:0] frequency;
  logic [rfm_pkg::TIME_W-1:0] last_report_time;
  logic [rfm_pkg::DATA_W-1:0] last_reported_value;

  // Finished result waiting for the output register.
  logic [rfm_pkg::DATA_W-1:0] res_freq;
  logic                       res_report;
  logic                       res_lost;

  logic                       accept;
  logic                       is_edge;
  logic [rfm_pkg::TIME_W-1:0] now;
  logic [rfm_pkg::TIME_W-1:0] period;
  logic                       need_div;
  logic                       push;

  rfm_pkg::div_req_t  div_req;
  rfm_pkg::div_rsp_t  div_rsp;
  rfm_pkg::poll_rsp_t poll_rsp;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign is_edge   = (s_tuser == rfm_pkg::OP_EDGE);
  assign now       = s_tdata[rfm_pkg::TIME_W-1:0];
  assign period    = now - last_edge_time;
  assign need_div  = is_edge && edge_seen && (period != '0);

  assign div_req.start = accept && need_div;
  assign div_req.num   = freq_numerator;
  assign div_req.den   = period;

  rfm_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rfm_poll u_poll (
    .now                 (now),
    .last_edge_time      (last_edge_time),
    .edge_seen           (edge_seen),
    .frequency           (frequency),
    .last_report_time    (last_report_time),
    .last_reported_value (last_reported_value),
    .timeout_us          (timeout_us),
    .report_interval_us  (report_interval_us),
    .change_spacing_us   (change_spacing_us),
    .rsp                 (poll_rsp)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rfm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = need_div ? rfm_pkg::ST_DIV : rfm_pkg::ST_PUSH;
        end
      end
      rfm_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = rfm_pkg::ST_PUSH;
        end
      end
      rfm_pkg::ST_PUSH: begin
        if (!m_tvalid || m_tready) begin
          state_next = rfm_pkg::ST_IDLE;
        end
      end
      default: state_next = rfm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    case (state)
      rfm_pkg::ST_IDLE: s_tready = 1'b1;
      rfm_pkg::ST_DIV:  s_tready = 1'b0;
      rfm_pkg::ST_PUSH: push = !m_tvalid || m_tready;
      default: begin
        s_tready = 1'b0;
        push     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_numerator     <= rfm_pkg::FREQ_NUMERATOR_RST;
      timeout_us         <= rfm_pkg::TIMEOUT_US_RST;
      report_interval_us <= rfm_pkg::REPORT_INTERVAL_US_RST;
      change_spacing_us  <= rfm_pkg::CHANGE_SPACING_US_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rfm_pkg::REG_FREQ_NUMERATOR:     freq_numerator     <= cfg_data;
        rfm_pkg::REG_TIMEOUT_US:         timeout_us         <= cfg_data;
        rfm_pkg::REG_REPORT_INTERVAL_US: report_interval_us <= cfg_data;
        rfm_pkg::REG_CHANGE_SPACING_US:  change_spacing_us  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Measurement state. Edges and polls update it when accepted; a divided edge
  // updates the frequency once the quotient is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time      <= '0;
      edge_seen           <= 1'b0;
      frequency           <= '0;
      last_report_time    <= '0;
      last_reported_value <= rfm_pkg::LAST_REPORTED_RST;
    end else if (accept) begin
      if (is_edge) begin
        last_edge_time <= now;
        edge_seen      <= 1'b1;
      end else begin
        if (poll_rsp.lost) begin
          frequency <= '0;
          edge_seen <= 1'b0;
        end
        if (poll_rsp.report) begin
          last_reported_value <= poll_rsp.freq;
          last_report_time    <= now;
        end
      end
    end else if ((state == rfm_pkg::ST_DIV) && div_rsp.done) begin
      frequency <= div_rsp.quot;
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_freq   <= is_edge ? frequency : poll_rsp.freq;
      res_report <= !is_edge && poll_rsp.report;
      res_lost   <= !is_edge && poll_rsp.lost;
    end else if ((state == rfm_pkg::ST_DIV) && div_rsp.done) begin
      res_freq <= div_rsp.quot;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= res_freq;
      m_tuser <= {res_lost, res_report};
    end
  end

endmodule

// ----- rtl/rfm_checker.sv -----
// Port-level checker for reciprocal_frequency_meter_unit, attached by a bind statement.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module rfm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // A timeout always reports a cleared frequency.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == 32'd0))
    else $error("signal lost with nonzero frequency");

  // One request is in work at a time: the input closes right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after acceptance");

endmodule

bind reciprocal_frequency_meter_unit rfm_checker u_rfm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- sim/tb_reciprocal_frequency_meter_unit.sv -----
// Self-checking testbench for reciprocal_frequency_meter_unit: directed edge and poll cases,
// then randomized edge trains, dropouts and noise under several register settings.
// Depends on rfm_pkg and the RTL of the meter; needs nothing else.
`timescale 1ns / 1ps

// Tracks the meter's state on every accepted request and holds the results it owes.
class meter_scoreboard;
  logic [31:0] numerator;
  logic [31:0] timeout;
  logic [31:0] interval;
  logic [31:0] spacing;
  logic [31:0] last_edge_time;
  logic [31:0] freq;
  logic [31:0] last_report_time;
  logic [31:0] last_report_value;
  bit          edge_seen;
  rfm_pkg::poll_rsp_t expected_results[$];
  int errors;
  int edges_sent;
  int polls_sent;
  int reports_due;
  int losses_due;

  function new();
    numerator         = rfm_pkg::FREQ_NUMERATOR_RST;
    timeout           = rfm_pkg::TIMEOUT_US_RST;
    interval          = rfm_pkg::REPORT_INTERVAL_US_RST;
    spacing           = rfm_pkg::CHANGE_SPACING_US_RST;
    last_edge_time    = '0;
    freq              = '0;
    last_report_time  = '0;
    last_report_value = rfm_pkg::LAST_REPORTED_RST;
    edge_seen         = 1'b0;
    errors            = 0;
    edges_sent        = 0;
    polls_sent        = 0;
    reports_due       = 0;
    losses_due        = 0;
  endfunction

  function void set_register(logic [rfm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      rfm_pkg::REG_FREQ_NUMERATOR:     numerator = value;
      rfm_pkg::REG_TIMEOUT_US:         timeout   = value;
      rfm_pkg::REG_REPORT_INTERVAL_US: interval  = value;
      rfm_pkg::REG_CHANGE_SPACING_US:  spacing   = value;
      default: ;
    endcase
  endfunction

  function void note_request(logic op, logic [31:0] now);
    rfm_pkg::poll_rsp_t rsp;
    logic [31:0] period;
    logic [31:0] since_edge;
    logic [31:0] since_report;
    rsp.lost   = 1'b0;
    rsp.report = 1'b0;
    if (op == rfm_pkg::OP_EDGE) begin
      edges_sent++;
      if (edge_seen) begin
        period = now - last_edge_time;
        // A repeated timestamp keeps the old frequency.
        if (period != 0)
          freq = numerator / period;
      end
      last_edge_time = now;
      edge_seen      = 1'b1;
    end else begin
      polls_sent++;
      since_edge = now - last_edge_time;
      if (edge_seen && since_edge > timeout) begin
        freq      = '0;
        edge_seen = 1'b0;
        rsp.lost  = 1'b1;
        losses_due++;
      end
      since_report = now - last_report_time;
      if (since_report >= interval ||
          (freq != last_report_value && since_report >= spacing)) begin
        rsp.report        = 1'b1;
        last_report_value = freq;
        last_report_time  = now;
        reports_due++;
      end
    end
    rsp.freq = freq;
    expected_results.push_back(rsp);
  endfunction

  function void check_result(logic [31:0] freq_out, logic [1:0] flags);
    rfm_pkg::poll_rsp_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result with no request pending: freq %h flags %b", $time, freq_out, flags);
      return;
    end
    want = expected_results.pop_front();
    if (freq_out !== want.freq) begin
      errors++;
      $display("%0t: freq_x100 expected %h actual %h", $time, want.freq, freq_out);
    end
    if (flags[0] !== want.report) begin
      errors++;
      $display("%0t: report_valid expected %b actual %b", $time, want.report, flags[0]);
    end
    if (flags[1] !== want.lost) begin
      errors++;
      $display("%0t: signal_lost expected %b actual %b", $time, want.lost, flags[1]);
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_reciprocal_frequency_meter_unit;
  import rfm_pkg::*;

  localparam int LIMIT_CYCLES    = 1000000;
  localparam int MAX_IDLE        = 14;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 172;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  meter_scoreboard sb;
  bit              sender_idles   = 1'b1;
  bit              receiver_idles = 1'b1;
  int              stall_left     = 0;
  int              rx_draw;
  int              cycles         = 0;
  int              settings_applied = 0;
  logic [31:0]     now_us;

  reciprocal_frequency_meter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("run stopped at the cycle limit with %0d results outstanding", sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check each accepted result, then hold ready low for a random stall.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
      rx_draw = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
      stall_left <= rx_draw;
      m_tready   <= (rx_draw == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Valid stays high across back-to-back requests; it only drops for a gap.
  task automatic send_request(input logic op, input logic [31:0] t);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, t);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value);
  endtask

  // Registers change only with the meter idle; an unknown index goes along each time.
  task automatic apply_settings(input logic [31:0] numer, input logic [31:0] tmo,
                                input logic [31:0] intv, input logic [31:0] spc);
    drain_results();
    cfg_write(CFG_IDX_W'($urandom_range(int'(REG_CHANGE_SPACING_US) + 1,
                                        (1 << CFG_IDX_W) - 1)), $urandom());
    cfg_write(REG_FREQ_NUMERATOR, numer);
    cfg_write(REG_TIMEOUT_US, tmo);
    cfg_write(REG_REPORT_INTERVAL_US, intv);
    cfg_write(REG_CHANGE_SPACING_US, spc);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic directed_checks();
    // Register defaults: polls with no edge yet, one far in the future.
    send_request(OP_POLL, 32'h0000_0000);
    send_request(OP_POLL, 32'hFFFF_FFFF);
    // First edge, then a repeated timestamp, then short periods.
    send_request(OP_EDGE, 32'd100);
    send_request(OP_EDGE, 32'd100);
    send_request(OP_EDGE, 32'd1100);
    send_request(OP_EDGE, 32'd1101);
    send_request(OP_POLL, 32'd300000);
    // Huge period, then one across the wrap of the timestamp.
    send_request(OP_EDGE, 32'hFFFF_FFF0);
    send_request(OP_EDGE, 32'h0000_0010);
    // Exactly at the timeout nothing is cleared; one microsecond later it is.
    send_request(OP_POLL, 32'h0000_0010 + TIMEOUT_US_RST);
    send_request(OP_POLL, 32'h0000_0011 + TIMEOUT_US_RST);
    send_request(OP_POLL, 32'h0000_0011 + TIMEOUT_US_RST);
    send_request(OP_EDGE, 32'd5000000);
    // Zero numerator and the widest timeout and intervals.
    apply_settings(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_EDGE, 32'd5000100);
    send_request(OP_POLL, 32'd0);
    // Largest numerator, zero timeout, report on every poll.
    apply_settings(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_request(OP_EDGE, 32'd7);
    send_request(OP_EDGE, 32'd8);
    send_request(OP_POLL, 32'd8);
    send_request(OP_POLL, 32'd9);
    send_request(OP_EDGE, 32'd9);
    send_request(OP_EDGE, 32'd8);
    send_request(OP_POLL, 32'd8);
  endtask

  // Edge trains with polls between them, occasional dropouts and random noise.
  task automatic random_phase(input int phase);
    logic [31:0] span;
    logic [31:0] period;
    logic [31:0] numer;
    logic [31:0] tmo;
    logic [31:0] intv;
    logic [31:0] spc;
    int          sent;
    int          run_len;
    span  = 32'd2000;
    numer = $urandom();
    tmo   = $urandom_range(0, 4 * span);
    intv  = $urandom_range(0, 8 * span);
    spc   = $urandom_range(0, 4 * span);
    case (phase)
      0: begin
        numer = FREQ_NUMERATOR_RST;
        tmo   = TIMEOUT_US_RST;
        intv  = REPORT_INTERVAL_US_RST;
        spc   = CHANGE_SPACING_US_RST;
        span  = 32'd400000;
      end
      1: begin
        numer = 32'hFFFF_FFFF;
        tmo   = 32'd0;
        intv  = 32'd0;
        spc   = 32'd0;
        span  = 32'd1000;
      end
      2: begin
        tmo  = 32'hFFFF_FFFF;
        intv = 32'hFFFF_FFFF;
        spc  = 32'hFFFF_FFFF;
        span = 32'd1 << 28;
      end
      3: numer = 32'd1;
      4: begin
        numer = 32'd0;
        span  = 32'd3000;
      end
      default: begin
        span  = $urandom_range(16, 32'd1 << 20);
        numer = $urandom_range(1, 32'hFFFF_FFFF);
        tmo   = $urandom_range(0, 4 * span);
        intv  = $urandom_range(0, 8 * span);
        spc   = $urandom_range(0, 4 * span);
      end
    endcase
    apply_settings(numer, tmo, intv, spc);
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0)
        drain_results();
      period  = $urandom_range(1, span);
      run_len = $urandom_range(4, 24);
      repeat (run_len) begin
        case ($urandom_range(0, 15))
          0: send_request(1'($urandom_range(0, 1)), $urandom());
          1: send_request(OP_EDGE, now_us);
          2, 3, 4, 5, 6, 7: begin
            now_us += period + $urandom_range(0, period >> 3);
            send_request(OP_EDGE, now_us);
          end
          default: begin
            now_us += $urandom_range(0, period);
            send_request(OP_POLL, now_us);
          end
        endcase
        sent++;
      end
      // The input goes quiet long enough to trip the timeout.
      if ($urandom_range(0, 5) == 0) begin
        now_us += tmo + $urandom_range(1, span);
        send_request(OP_POLL, now_us);
        sent++;
      end
    end
  endtask

  initial begin
    sb        = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_EDGE;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    now_us    = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_checks();
    for (int p = 0; p < PHASES; p++)
      random_phase(p);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d edges and %0d polls under %0d register settings",
             sb.edges_sent, sb.polls_sent, settings_applied);
    $display("%0d reports and %0d signal losses were predicted", sb.reports_due, sb.losses_due);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/rfm_pkg.sv
rtl/rfm_divider.sv
rtl/rfm_poll.sv
rtl/reciprocal_frequency_meter_unit.sv
rtl/rfm_checker.sv
sim/tb_reciprocal_frequency_meter_unit.sv
